// File: sv/clat_pkg.sv
// ----------------------------------------------------------------------------
// clat_pkg
// Shared types and constants for the command line argument tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package clat_pkg;

	localparam int unsigned MAX_ARGUMENTS      = 16;
	localparam int unsigned MAX_ARGUMENT_UNITS = 32767;

	localparam logic [15:0] UNIT_END    = 16'h0000;
	localparam logic [15:0] UNIT_QUOTE  = 16'h0022;
	localparam logic [15:0] UNIT_BSLASH = 16'h005C;
	localparam logic [15:0] UNIT_SPACE  = 16'h0020;
	localparam logic [15:0] UNIT_TAB    = 16'h0009;

	// parser state carried from one code unit to the next
	typedef struct packed {
		logic        inside_quotes;
		logic        inside_argument;
		logic        quote_pending;
		logic [15:0] pending_backslashes;
		logic [14:0] units_in_argument;
		logic [4:0]  arguments_seen;
		logic        error_seen;
	} clat_state_t;

	// one result item
	typedef struct packed {
		logic [14:0] backslash_run;
		logic        has_char;
		logic [15:0] char_value;
		logic        end_of_argument;
		logic [3:0]  argument_index;
		logic        line_done;
		logic        failed;
		logic [4:0]  argument_total;
	} clat_result_t;

endpackage

`default_nettype wire

// File: sv/command_line_argument_tokenizer_core.sv
// ----------------------------------------------------------------------------
// command_line_argument_tokenizer_core
// Splits a UTF-16 command line into arguments under Windows quoting rules.
// ----------------------------------------------------------------------------
// Path: an accepted code unit passes the input register, then the result
//   register; units that give no result are absorbed silently.
// Throughput: 1 code unit per cycle unless a result waits on out_stall.
// Reset: arst_n clears the parser state and both valid flags asynchronously.
`default_nettype none

module command_line_argument_tokenizer_core import clat_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] code_unit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [14:0]      backslash_run,
	output logic             has_char,
	output logic [15:0]      char_value,
	output logic             end_of_argument,
	output logic [3:0]       argument_index,
	output logic             line_done,
	output logic             failed,
	output logic [4:0]       argument_total
);

	logic         valid_s1;
	logic [15:0]  unit_s1;
	clat_state_t  state_q;
	clat_state_t  state_nxt;
	logic         res_valid;
	clat_result_t res;
	clat_result_t res_q;
	logic         out_valid_q;
	logic         out_free;
	logic         advance;

	clat_step u_step (
		.code_unit (unit_s1),
		.cur       (state_q),
		.nxt       (state_nxt),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!res_valid || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance && res_valid) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			unit_s1 <= code_unit;
		end
		if (advance && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid       = out_valid_q;
	assign backslash_run   = res_q.backslash_run;
	assign has_char        = res_q.has_char;
	assign char_value      = res_q.char_value;
	assign end_of_argument = res_q.end_of_argument;
	assign argument_index  = res_q.argument_index;
	assign line_done       = res_q.line_done;
	assign failed          = res_q.failed;
	assign argument_total  = res_q.argument_total;

endmodule

`default_nettype wire

// File: sv/clat_step.sv
// ----------------------------------------------------------------------------
// clat_step
// Next-state and result logic for one code unit of the command line.
// ----------------------------------------------------------------------------
`default_nettype none

module clat_step import clat_pkg::*; (
	input  wire logic [15:0] code_unit,
	input  clat_state_t      cur,
	output clat_state_t      nxt,
	output logic             res_valid,
	output clat_result_t     res
);

	// units + extra still within the argument length limit
	function automatic logic fits(input logic [14:0] units, input logic [16:0] extra);
		logic [17:0] sum;
		sum = {3'b000, units} + {1'b0, extra};
		return sum <= 18'(MAX_ARGUMENT_UNITS);
	endfunction

	logic        blank;
	logic        iq_v;
	logic [14:0] units_v;
	logic [15:0] pend_v;
	logic [16:0] pend_inc;
	logic [14:0] half;
	logic        odd;
	logic [16:0] extra;

	assign blank = (code_unit == UNIT_SPACE) || (code_unit == UNIT_TAB);

	always_comb begin
		nxt       = cur;
		res_valid = 1'b0;
		res       = '0;
		res.argument_index = cur.arguments_seen[3:0];
		iq_v      = cur.quote_pending ? 1'b0 : cur.inside_quotes;
		units_v   = cur.inside_argument ? cur.units_in_argument : 15'd0;
		pend_v    = cur.inside_argument ? cur.pending_backslashes : 16'd0;
		pend_inc  = {1'b0, pend_v} + 17'd1;
		half      = pend_v[15:1];
		odd       = pend_v[0];
		extra     = '0;

		if (cur.error_seen) begin
			if (code_unit == UNIT_END) begin
				res_valid     = 1'b1;
				res.line_done = 1'b1;
				res.failed    = 1'b1;
				nxt           = '0;
			end
		end else if (cur.quote_pending && code_unit == UNIT_QUOTE) begin
			// doubled quote inside quotes: one literal quote
			nxt.quote_pending = 1'b0;
			res_valid = 1'b1;
			if (!fits(cur.units_in_argument, 17'd1)) begin
				nxt.error_seen = 1'b1;
				res.failed     = 1'b1;
			end else begin
				nxt.units_in_argument = cur.units_in_argument + 15'd1;
				res.has_char   = 1'b1;
				res.char_value = UNIT_QUOTE;
			end
		end else begin
			nxt.quote_pending = 1'b0;
			nxt.inside_quotes = iq_v;
			if (code_unit == UNIT_END) begin
				res_valid = 1'b1;
				res.line_done = 1'b1;
				nxt = '0;
				if (iq_v) begin
					res.failed = 1'b1;
				end else if (cur.inside_argument &&
					!fits(cur.units_in_argument, {1'b0, cur.pending_backslashes})) begin
					res.failed = 1'b1;
				end else begin
					res.backslash_run   = cur.pending_backslashes[14:0];
					res.end_of_argument = cur.inside_argument;
					res.argument_total  = cur.arguments_seen +
						{4'd0, cur.inside_argument};
				end
			end else if (!cur.inside_argument && blank) begin
				// separator between arguments: nothing to report
			end else if (!cur.inside_argument &&
				cur.arguments_seen >= 5'(MAX_ARGUMENTS)) begin
				res_valid      = 1'b1;
				res.failed     = 1'b1;
				nxt.error_seen = 1'b1;
			end else begin
				nxt.inside_argument     = 1'b1;
				nxt.units_in_argument   = units_v;
				nxt.pending_backslashes = pend_v;
				if (code_unit == UNIT_BSLASH) begin
					nxt.pending_backslashes = pend_inc[15:0];
					// fail early once every ending of the run overflows
					if (!fits(units_v, {1'b0, pend_inc[16:1]})) begin
						res_valid      = 1'b1;
						res.failed     = 1'b1;
						nxt.error_seen = 1'b1;
					end
				end else if (code_unit == UNIT_QUOTE) begin
					nxt.pending_backslashes = '0;
					extra = {2'b00, half} + {16'd0, odd};
					if (!fits(units_v, extra)) begin
						res_valid      = 1'b1;
						res.failed     = 1'b1;
						nxt.error_seen = 1'b1;
					end else begin
						nxt.units_in_argument = units_v + extra[14:0];
						res.backslash_run = half;
						if (odd) begin
							res_valid      = 1'b1;
							res.has_char   = 1'b1;
							res.char_value = UNIT_QUOTE;
						end else begin
							res_valid = (half != 15'd0);
							if (iq_v) begin
								nxt.quote_pending = 1'b1;
							end else begin
								nxt.inside_quotes = 1'b1;
							end
						end
					end
				end else begin
					nxt.pending_backslashes = '0;
					res_valid = 1'b1;
					if (!iq_v && blank) begin
						if (!fits(units_v, {1'b0, pend_v})) begin
							res.failed     = 1'b1;
							nxt.error_seen = 1'b1;
						end else begin
							res.backslash_run     = pend_v[14:0];
							res.end_of_argument   = 1'b1;
							nxt.arguments_seen    = cur.arguments_seen + 5'd1;
							nxt.inside_argument   = 1'b0;
							nxt.units_in_argument = '0;
						end
					end else begin
						extra = {1'b0, pend_v} + 17'd1;
						if (!fits(units_v, extra)) begin
							res.failed     = 1'b1;
							nxt.error_seen = 1'b1;
						end else begin
							nxt.units_in_argument = units_v + extra[14:0];
							res.backslash_run = pend_v[14:0];
							res.has_char      = 1'b1;
							res.char_value    = code_unit;
						end
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: sv/clat_checker.sv
// ----------------------------------------------------------------------------
// clat_checker
// Port-level checks on the tokenizer core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module clat_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [14:0] backslash_run,
	input wire logic        has_char,
	input wire logic [15:0] char_value,
	input wire logic        end_of_argument,
	input wire logic        line_done,
	input wire logic        failed,
	input wire logic [4:0]  argument_total
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(char_value) &&
		$stable(backslash_run) && $stable(line_done))
		else $error("stalled result changed");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && failed |-> !has_char && backslash_run == 15'd0 &&
		!end_of_argument && argument_total == 5'd0)
		else $error("failure result carries data");

	a_total_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_done |-> argument_total == 5'd0)
		else $error("argument total outside line end");

	a_done_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> !has_char && argument_total <= 5'd16)
		else $error("line end result malformed");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_char |-> char_value == 16'd0)
		else $error("char value without char");

endmodule

bind command_line_argument_tokenizer_core clat_checker u_clat_checker (.*);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command line argument tokenizer: feeds code
// units (directed cases, random lines and noise, then the directed cases
// again at full rate), predicts every result from an internal parser model
// and checks each output transaction field by field.
// ----------------------------------------------------------------------------

module tb;

	import clat_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200_000;
	localparam int unsigned DRAIN_CYCLES  = 16;
	localparam int unsigned PARSED_TARGET = 1000;
	localparam int unsigned TAIL_PASSES   = 4;
	localparam int unsigned PRINT_LIMIT   = 50;

	localparam logic [15:0] DIRECTED_UNITS [25] = '{
		UNIT_END, 16'hFFFF, UNIT_BSLASH, UNIT_BSLASH, UNIT_QUOTE, UNIT_SPACE,
		UNIT_QUOTE, UNIT_QUOTE, UNIT_BSLASH, UNIT_QUOTE, UNIT_QUOTE, UNIT_TAB,
		UNIT_BSLASH, 16'h0001, UNIT_QUOTE, UNIT_QUOTE, UNIT_END, UNIT_QUOTE,
		16'h0062, UNIT_END, UNIT_BSLASH, UNIT_END, 16'h0063, UNIT_SPACE, UNIT_END
	};

	// parser model plus the store of results still owed by the block
	class argv_scoreboard;
		clat_result_t expected_pieces[$];
		int unsigned  errors;
		int unsigned  units_parsed;
		int unsigned  results_seen;
		bit           quoted;
		bit           in_arg;
		bit           quote_held;
		bit           err;
		logic [16:0]  bs_held;
		logic [14:0]  arg_units;
		logic [4:0]   args_done;

		function new();
			errors = 0;
			units_parsed = 0;
			results_seen = 0;
			clear_line();
		endfunction

		function void clear_line();
			quoted = 0;
			in_arg = 0;
			quote_held = 0;
			err = 0;
			bs_held = '0;
			arg_units = '0;
			args_done = '0;
		endfunction

		function bit fits(int unsigned extra);
			return (int'(arg_units) + extra) <= MAX_ARGUMENT_UNITS;
		endfunction

		function void push_result(int unsigned run, bit has, logic [15:0] ch, bit eoa,
				bit done, bit fail, int unsigned total);
			clat_result_t r;
			r.backslash_run   = 15'(run);
			r.has_char        = has;
			r.char_value      = ch;
			r.end_of_argument = eoa;
			r.argument_index  = args_done[3:0];
			r.line_done       = done;
			r.failed          = fail;
			r.argument_total  = 5'(total);
			expected_pieces.push_back(r);
		endfunction

		function void flag_error();
			err = 1;
			push_result(0, 0, 16'h0000, 0, 0, 1, 0);
		endfunction

		function void finish_failed_line();
			push_result(0, 0, 16'h0000, 0, 1, 1, 0);
			clear_line();
		endfunction

		// one accepted code unit in, zero or one expected result out
		function void tokenize_unit(logic [15:0] u);
			bit blank;
			int unsigned run;
			int unsigned half;
			blank = (u == UNIT_SPACE) || (u == UNIT_TAB);
			if (err) begin
				if (u == UNIT_END)
					finish_failed_line();
				return;
			end
			units_parsed++;
			if (quote_held) begin
				quote_held = 0;
				if (u == UNIT_QUOTE) begin
					if (!fits(1)) begin
						flag_error();
						return;
					end
					arg_units = arg_units + 15'd1;
					push_result(0, 1, UNIT_QUOTE, 0, 0, 0, 0);
					return;
				end
				quoted = 0;
			end
			if (u == UNIT_END) begin
				// a quote still held at the end has already closed the quotes
				if (quoted || (in_arg && !fits(bs_held))) begin
					finish_failed_line();
					return;
				end
				push_result(bs_held, 0, 16'h0000, in_arg, 1, 0, args_done + in_arg);
				clear_line();
				return;
			end
			if (!in_arg) begin
				if (blank)
					return;
				if (args_done >= MAX_ARGUMENTS) begin
					flag_error();
					return;
				end
				in_arg = 1;
				arg_units = '0;
				bs_held = '0;
			end
			if (u == UNIT_BSLASH) begin
				bs_held = bs_held + 17'd1;
				// every ending of this run overflows once half of it no longer fits
				if (!fits(bs_held >> 1))
					flag_error();
				return;
			end
			if (u == UNIT_QUOTE) begin
				half = bs_held >> 1;
				run = bs_held[0];
				bs_held = '0;
				if (run != 0) begin
					if (!fits(half + 1)) begin
						flag_error();
						return;
					end
					arg_units = arg_units + 15'(half + 1);
					push_result(half, 1, UNIT_QUOTE, 0, 0, 0, 0);
					return;
				end
				if (!fits(half)) begin
					flag_error();
					return;
				end
				arg_units = arg_units + 15'(half);
				if (quoted)
					quote_held = 1;
				else
					quoted = 1;
				if (half != 0)
					push_result(half, 0, 16'h0000, 0, 0, 0, 0);
				return;
			end
			run = bs_held;
			bs_held = '0;
			if (!quoted && blank) begin
				if (!fits(run)) begin
					flag_error();
					return;
				end
				push_result(run, 0, 16'h0000, 1, 0, 0, 0);
				args_done = args_done + 5'd1;
				in_arg = 0;
				arg_units = '0;
				return;
			end
			if (!fits(run + 1)) begin
				flag_error();
				return;
			end
			arg_units = arg_units + 15'(run + 1);
			push_result(run, 1, u, 0, 0, 0, 0);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("ERROR: %s", msg);
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
					results_seen, name, got, want));
		endtask

		task check_result(clat_result_t got);
			clat_result_t want;
			results_seen++;
			if (expected_pieces.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
				return;
			end
			want = expected_pieces.pop_front();
			check_field("backslash_run", got.backslash_run, want.backslash_run);
			check_field("has_char", got.has_char, want.has_char);
			check_field("char_value", got.char_value, want.char_value);
			check_field("end_of_argument", got.end_of_argument, want.end_of_argument);
			check_field("argument_index", got.argument_index, want.argument_index);
			check_field("line_done", got.line_done, want.line_done);
			check_field("failed", got.failed, want.failed);
			check_field("argument_total", got.argument_total, want.argument_total);
		endtask

		task close_out();
			if (expected_pieces.size() != 0)
				report($sformatf("%0d expected results never arrived",
					expected_pieces.size()));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [15:0] code_unit = 16'h0000;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [14:0] backslash_run;
	logic        has_char;
	logic [15:0] char_value;
	logic        end_of_argument;
	logic [3:0]  argument_index;
	logic        line_done;
	logic        failed;
	logic [4:0]  argument_total;

	bit             idling = 1'b0;
	int unsigned    cycle_count = 0;
	argv_scoreboard sb = new();

	command_line_argument_tokenizer_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.code_unit       (code_unit),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.backslash_run   (backslash_run),
		.has_char        (has_char),
		.char_value      (char_value),
		.end_of_argument (end_of_argument),
		.argument_index  (argument_index),
		.line_done       (line_done),
		.failed          (failed),
		.argument_total  (argument_total)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// sample both channels on the edge that completes each transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.tokenize_unit(code_unit);
			if (out_valid && !out_stall)
				sb.check_result({backslash_run, has_char, char_value, end_of_argument,
					argument_index, line_done, failed, argument_total});
		end
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver back-pressure in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idling && arst_n && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// called at a rising edge; returns at the edge that accepts the unit
	task automatic send_unit(input logic [15:0] u);
		if (idling && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_unit <= u;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	function automatic logic [15:0] content_unit();
		case ($urandom_range(0, 9))
			0, 1: return UNIT_BSLASH;
			2: return UNIT_QUOTE;
			3: return ($urandom_range(0, 1) != 0) ? UNIT_SPACE : UNIT_TAB;
			4: return 16'($urandom_range(1, 65535));
			default: return 16'h0061 + 16'($urandom_range(0, 25));
		endcase
	endfunction

	// mostly well-formed lines; some crowd past the argument limit, some are raw noise
	task automatic send_random_line();
		int unsigned mode;
		int unsigned n_args;
		int unsigned n_units;
		bit wrap;
		mode = $urandom_range(0, 9);
		idling = ($urandom_range(0, 4) != 0);
		if (mode == 0) begin
			repeat ($urandom_range(1, 8))
				send_unit(16'($urandom_range(0, 65535)));
			return;
		end
		n_args = (mode == 1) ? $urandom_range(15, 19) : $urandom_range(0, 6);
		repeat (n_args) begin
			repeat ($urandom_range(0, 2))
				send_unit(($urandom_range(0, 1) != 0) ? UNIT_SPACE : UNIT_TAB);
			wrap = ($urandom_range(0, 2) == 0);
			if (wrap)
				send_unit(UNIT_QUOTE);
			n_units = (mode == 1) ? $urandom_range(1, 2) : $urandom_range(0, 8);
			repeat (n_units)
				send_unit(content_unit());
			if (wrap)
				send_unit(UNIT_QUOTE);
			send_unit(UNIT_SPACE);
		end
		send_unit(UNIT_END);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		idling = 1'b1;
		foreach (DIRECTED_UNITS[i])
			send_unit(DIRECTED_UNITS[i]);

		while (sb.units_parsed < PARSED_TARGET)
			send_random_line();

		// directed cases again back to back, no idling from here on
		idling = 1'b0;
		repeat (TAIL_PASSES)
			foreach (DIRECTED_UNITS[i])
				send_unit(DIRECTED_UNITS[i]);

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_pieces.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
